FILE: sv/tcp_passive_open_receiver_core_assert.svh
// Assertion macros for the receiver core.
`ifndef TCP_PASSIVE_OPEN_RECEIVER_CORE_ASSERT_SVH
`define TCP_PASSIVE_OPEN_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define TPOR_ASSERT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define TPOR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TPOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPOR_ASSERT(lbl, clk, rst_n, cond, msg)
`define TPOR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TPOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/tpor_pkg.sv
`default_nettype none

package tpor_pkg;

	localparam logic [15:0] DEFAULT_WINDOW = 16'd1024;
	localparam int unsigned BYTES_PER_WORD = 4;
	localparam int unsigned HDR_BYTES_W = 7;

	// configuration register indexes
	localparam logic CFG_ISS  = 1'b0;
	localparam logic CFG_LWIN = 1'b1;

	typedef enum logic [1:0] {
		CS_NONE    = 2'd0,
		CS_SYNRCVD = 2'd1,
		CS_ESTAB   = 2'd2
	} conn_state_t;

	typedef enum logic [2:0] {
		V_IGNORED = 3'd0,
		V_SYNACK  = 3'd1,
		V_BADACK  = 3'd2,
		V_BADSEQ  = 3'd3,
		V_NOACK   = 3'd4,
		V_ACCEPT  = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic        flag_syn;
		logic        flag_ack;
		logic        flag_fin;
		logic [15:0] ip_total_len;
		logic [3:0]  ip_hdr_words;
		logic [3:0]  tcp_hdr_words;
		logic [15:0] seg_window;
	} seg_in_t;

	typedef struct packed {
		logic        send_synack;
		logic [31:0] reply_seq;
		logic [31:0] reply_ack;
		logic [15:0] reply_window;
		logic [2:0]  verdict;
		logic [1:0]  conn_state_out;
	} result_t;

	// classified segment handed from front to back
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ack;
		logic        syn;
		logic        ackf;
		logic [31:0] seq_p1;
		logic [31:0] seq_last;
		logic        len_zero;
		logic [15:0] win;
	} desc_t;

endpackage

`default_nettype wire

FILE: sv/tcp_passive_open_receiver_core.sv
// A word accepted into the front queue goes through the back-end step into the output queue
// and from there onto the result ports; a full output queue stalls the back end.
// Throughput: one segment per cycle while the output queue is not full; the control block
// update is computed combinationally in the back end and registered as each segment moves on.
// Reset (arst_n low): queues empty, no connection, ISS 0, local window 1024.
`default_nettype none

module tcp_passive_open_receiver_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire tpor_pkg::seg_in_t seg,
	output logic                  empty,
	input  wire logic             pop,
	output tpor_pkg::result_t     result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [31:0]      cfg_wdata
);

	tpor_pkg::desc_t   desc;
	tpor_pkg::result_t res;
	logic              desc_valid;
	logic              desc_pop;
	logic              res_push;
	logic              res_full;

	tpor_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.seg        (seg),
		.desc_valid (desc_valid),
		.desc_pop   (desc_pop),
		.desc       (desc)
	);

	tpor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.desc_valid (desc_valid),
		.desc_pop   (desc_pop),
		.desc       (desc),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	tpor_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_full (res_full),
		.wr_data (res),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire

FILE: sv/tpor_front.sv
`default_nettype none

module tpor_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire tpor_pkg::seg_in_t seg,
	output logic                  desc_valid,
	input  wire logic             desc_pop,
	output tpor_pkg::desc_t       desc
);

	tpor_pkg::desc_t desc_d;
	tpor_pkg::desc_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;

	logic [4:0]                        hdr_words;
	logic [tpor_pkg::HDR_BYTES_W-1:0]  hdr_bytes;
	logic [15:0]                       hdr_ext;
	logic [15:0]                       pay_len;
	logic [16:0]                       len;

	always_comb begin
		hdr_words = {1'b0, seg.ip_hdr_words} + {1'b0, seg.tcp_hdr_words};
		hdr_bytes = tpor_pkg::HDR_BYTES_W'(hdr_words * tpor_pkg::BYTES_PER_WORD);
		hdr_ext   = {{(16 - tpor_pkg::HDR_BYTES_W){1'b0}}, hdr_bytes};
		pay_len   = (seg.ip_total_len > hdr_ext) ? (seg.ip_total_len - hdr_ext) : 16'd0;
		// SYN and FIN each take one sequence number
		len       = {1'b0, pay_len} + {16'd0, seg.flag_syn} + {16'd0, seg.flag_fin};

		desc_d.seq      = seg.seg_seq;
		desc_d.ack      = seg.seg_ack;
		desc_d.syn      = seg.flag_syn;
		desc_d.ackf     = seg.flag_ack;
		desc_d.seq_p1   = seg.seg_seq + 32'd1;
		desc_d.seq_last = seg.seg_seq + {15'd0, len} - 32'd1;
		desc_d.len_zero = (len == 17'd0);
		desc_d.win      = seg.seg_window;
	end

	assign full       = (cnt_q == 2'd2);
	assign desc_valid = (cnt_q != 2'd0);
	assign do_push    = push && !full;
	assign do_pop     = desc_pop && desc_valid;
	assign desc       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= desc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/tpor_back.sv
`default_nettype none

`include "tcp_passive_open_receiver_core_assert.svh"

module tpor_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [31:0]      cfg_wdata,
	input  wire logic             desc_valid,
	output logic                  desc_pop,
	input  wire tpor_pkg::desc_t  desc,
	input  wire logic             res_full,
	output logic                  res_push,
	output tpor_pkg::result_t     res
);

	logic [31:0] iss_q;
	logic [15:0] lwin_q;

	tpor_pkg::conn_state_t state_q;
	tpor_pkg::conn_state_t state_d;
	logic [31:0] snd_una_q;
	logic [31:0] snd_nxt_q;
	logic [31:0] rcv_nxt_q;
	logic [15:0] rcv_wnd_q;

	logic        fire;
	logic [31:0] d_una_ack;
	logic [31:0] d_ack_nxt;
	logic [31:0] off_first;
	logic [31:0] off_last;
	logic        ack_ok;
	logic        win_first;
	logic        win_last;
	logic        wnd_zero;
	logic        seq_ok;

	assign fire     = desc_valid && !res_full;
	assign desc_pop = fire;
	assign res_push = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 32'd0;
			lwin_q <= tpor_pkg::DEFAULT_WINDOW;
		end else if (cfg_we) begin
			case (cfg_index)
				tpor_pkg::CFG_ISS:  iss_q  <= cfg_wdata;
				tpor_pkg::CFG_LWIN: lwin_q <= cfg_wdata[15:0];
				default:            iss_q  <= iss_q;
			endcase
		end
	end

	// serial compares: a < b when bit 31 of a - b is set
	always_comb begin
		d_una_ack = snd_una_q - desc.ack;
		d_ack_nxt = desc.ack - snd_nxt_q;
		ack_ok    = d_una_ack[31] && ((desc.ack == snd_nxt_q) || d_ack_nxt[31]);
		off_first = desc.seq - rcv_nxt_q;
		off_last  = desc.seq_last - rcv_nxt_q;
		win_first = off_first < {16'd0, rcv_wnd_q};
		win_last  = off_last < {16'd0, rcv_wnd_q};
		wnd_zero  = (rcv_wnd_q == 16'd0);
		if (desc.len_zero) begin
			seq_ok = wnd_zero ? (desc.seq == rcv_nxt_q) : win_first;
		end else begin
			seq_ok = !wnd_zero && (win_first || win_last);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tpor_pkg::CS_NONE: begin
				if (fire && desc.syn) begin
					state_d = tpor_pkg::CS_SYNRCVD;
				end
			end
			tpor_pkg::CS_SYNRCVD: begin
				if (fire && ack_ok && seq_ok && desc.ackf) begin
					state_d = tpor_pkg::CS_ESTAB;
				end
			end
			default: state_d = state_q;
		endcase
	end

	always_comb begin
		res                = '0;
		res.conn_state_out = state_d;
		case (state_q)
			tpor_pkg::CS_NONE: begin
				if (desc.syn) begin
					res.send_synack  = 1'b1;
					res.reply_seq    = iss_q;
					res.reply_ack    = desc.seq_p1;
					res.reply_window = lwin_q;
					res.verdict      = tpor_pkg::V_SYNACK;
				end else begin
					res.verdict = tpor_pkg::V_IGNORED;
				end
			end
			default: begin
				if (!ack_ok) begin
					res.verdict = tpor_pkg::V_BADACK;
				end else if (!seq_ok) begin
					res.verdict = tpor_pkg::V_BADSEQ;
				end else if (state_q == tpor_pkg::CS_SYNRCVD && !desc.ackf) begin
					res.verdict = tpor_pkg::V_NOACK;
				end else begin
					res.verdict = tpor_pkg::V_ACCEPT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tpor_pkg::CS_NONE;
			snd_una_q <= 32'd0;
			snd_nxt_q <= 32'd0;
			rcv_nxt_q <= 32'd0;
			rcv_wnd_q <= 16'd0;
		end else begin
			state_q <= state_d;
			if (fire && state_q == tpor_pkg::CS_NONE && desc.syn) begin
				snd_una_q <= iss_q;
				snd_nxt_q <= iss_q + 32'd1;
				rcv_nxt_q <= desc.seq_p1;
				rcv_wnd_q <= desc.win;
			end
		end
	end

	`TPOR_ASSERT_NEXT(a_syn_opens, clk, arst_n, fire && state_q == tpor_pkg::CS_NONE && desc.syn, state_q == tpor_pkg::CS_SYNRCVD, "SYN did not open connection")
	`TPOR_ASSERT_NEXT(a_hold_idle, clk, arst_n, !fire, $stable(state_q) && $stable(rcv_nxt_q), "state moved without a word")
	`TPOR_ASSERT_NEXT(a_estab_stays, clk, arst_n, state_q == tpor_pkg::CS_ESTAB, state_q == tpor_pkg::CS_ESTAB, "left ESTABLISHED")
	`TPOR_ASSERT(a_nxt_una, clk, arst_n, state_q == tpor_pkg::CS_NONE || snd_nxt_q == snd_una_q + 32'd1, "snd_nxt out of step with snd_una")
	`TPOR_ASSERT_IMPL(a_synack_only, clk, arst_n, res_push && res.send_synack, state_q == tpor_pkg::CS_NONE, "SYN-ACK on live connection")

endmodule

`default_nettype wire

FILE: sv/tpor_outq.sv
`default_nettype none

module tpor_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	output logic                  wr_full,
	input  wire tpor_pkg::result_t wr_data,
	input  wire logic             pop,
	output logic                  empty,
	output tpor_pkg::result_t     result
);

	tpor_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_wr;
	logic              do_pop;

	assign wr_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr && !wr_full;
	assign do_pop  = pop && !empty;
	assign result  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire
